/* sv/wcdfs_pkg.sv */
package wcdfs_pkg;

  localparam int MAX_FRAMES = 64;

  // highest frame index reported, also capped by the 6-bit field
  localparam int FRAME_LIM_I = (MAX_FRAMES - 1 > 63) ? 63 : (MAX_FRAMES - 1);
  localparam logic [5:0] FRAME_LIM = 6'(FRAME_LIM_I);

  // configuration register indexes
  localparam logic [0:0] CFG_PICK_FARTHEST = 1'd0;
  localparam logic [0:0] CFG_REF_SOURCE    = 1'd1;

  // reference source codes
  localparam logic [1:0] REF_INPUT = 2'd0;
  localparam logic [1:0] REF_BLACK = 2'd1;
  localparam logic [1:0] REF_WHITE = 2'd2;

  // sequencer step limits
  localparam logic [3:0] MUL_LAST  = 4'd4;
  localparam logic [3:0] ROOT_LAST = 4'd13;

  // first trial bit of the root: 4^13, top even bit below 2^28
  localparam logic [27:0] ROOT_BIT0 = 28'h400_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT,
    ST_UPD
  } wcdfs_state_t;

endpackage

/* sv/weighted_color_distance_frame_select_top.sv */
// Channel   Dir  Payload
// in_       in   tdata: cand_c0, cand_c1, cand_c2, ref_c0, ref_c1, ref_c2;
//                tuser: first_frame; tlast: last_frame
// out_      out  tdata: out_c0, out_c1, out_c2, chosen_frame, chosen_distance
// cfg_      in   idx 0 pick_farthest, idx 1 reference_source
//
// Each word passes one accept step, 5 steps on the shared 16x10
// multiplier-accumulator, 14 steps of the bit-serial square root and one update step.
// A last-marked word also waits in the update step while a previous result
// is still held in the output register.
// rst_n is synchronous, active low; it clears control state and the selection.
module weighted_color_distance_frame_select_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cand_c0, cand_c1, cand_c2, ref_c0, ref_c1, ref_c2
  input  logic        in_tuser,   // first_frame
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_c0, out_c1, out_c2, chosen_frame, chosen_distance
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [1:0]  cfg_wdata
);
  import wcdfs_pkg::*;

  wcdfs_state_t state_r, state_nxt;
  logic [3:0]  cnt_r;
  logic        pick_far_r;
  logic [1:0]  ref_src_r;

  logic [7:0]  d0_r, d1_r, d2_r, m_r;
  logic [23:0] pix_r;
  logic        first_r, last_r;

  logic [15:0] sq_r;
  logic [27:0] acc_r;   // weighted sum, then root remainder
  logic [27:0] res_r;
  logic [27:0] bit_r;

  logic [9:0]  best_dist_r;
  logic [5:0]  best_idx_r;
  logic [23:0] best_pix_r;
  logic [5:0]  fc_r;
  logic        open_r;

  logic        out_valid_r;
  logic [39:0] out_data_r;

  logic        accept, out_free, upd_go;
  logic [7:0]  r0, r1, r2;
  logic [15:0] mul_a;
  logic [9:0]  mul_b;
  logic [25:0] prod;
  logic [27:0] trial;
  logic [9:0]  cur_dist;
  logic        restart, take;
  logic [5:0]  fc_new;
  logic [9:0]  nb_dist;
  logic [5:0]  nb_idx;
  logic [23:0] nb_pix;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // reference select
  always_comb begin
    unique case (ref_src_r)
      REF_BLACK: begin
        r0 = 8'h00; r1 = 8'h00; r2 = 8'h00;
      end
      REF_WHITE: begin
        r0 = 8'hFF; r1 = 8'hFF; r2 = 8'hFF;
      end
      default: begin
        r0 = in_tdata[31:24]; r1 = in_tdata[39:32]; r2 = in_tdata[47:40];
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (cnt_r)
      4'd0:    begin mul_a = {8'd0, d0_r}; mul_b = {2'd0, d0_r}; end
      4'd1:    begin mul_a = sq_r;         mul_b = 10'd512 + {2'd0, m_r}; end
      4'd2:    begin mul_a = {8'd0, d1_r}; mul_b = {2'd0, d1_r}; end
      4'd3:    begin mul_a = {8'd0, d2_r}; mul_b = {2'd0, d2_r}; end
      default: begin mul_a = sq_r;         mul_b = 10'd767 - {2'd0, m_r}; end
    endcase
  end
  assign prod     = mul_a * mul_b;
  assign trial    = res_r + bit_r;
  assign cur_dist = res_r[13:4];

  // selection update
  always_comb begin
    restart = first_r || !open_r;
    if (restart) begin
      fc_new = 6'd0;
      take   = 1'b1;
    end else begin
      fc_new = (fc_r < FRAME_LIM) ? fc_r + 6'd1 : fc_r;
      take   = pick_far_r ? (cur_dist > best_dist_r) : (cur_dist < best_dist_r);
    end
    nb_dist = take ? cur_dist : best_dist_r;
    nb_idx  = take ? fc_new   : best_idx_r;
    nb_pix  = take ? pix_r    : best_pix_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MUL;
      ST_MUL:  if (cnt_r == MUL_LAST) state_nxt = ST_ROOT;
      ST_ROOT: if (cnt_r == ROOT_LAST) state_nxt = ST_UPD;
      ST_UPD:  if (!last_r || out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    upd_go    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_UPD:  upd_go = !last_r || out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= 4'd0;
      pick_far_r <= 1'b0;
      ref_src_r  <= REF_INPUT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_nxt != state_r) ? 4'd0 : cnt_r + 4'd1;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PICK_FARTHEST: pick_far_r <= cfg_wdata[0];
          CFG_REF_SOURCE:    ref_src_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      d0_r    <= (in_tdata[7:0]   > r0) ? in_tdata[7:0]   - r0 : r0 - in_tdata[7:0];
      d1_r    <= (in_tdata[15:8]  > r1) ? in_tdata[15:8]  - r1 : r1 - in_tdata[15:8];
      d2_r    <= (in_tdata[23:16] > r2) ? in_tdata[23:16] - r2 : r2 - in_tdata[23:16];
      m_r     <= 8'(({1'b0, in_tdata[7:0]} + {1'b0, r0}) >> 1);
      pix_r   <= in_tdata[23:0];
      first_r <= in_tuser;
      last_r  <= in_tlast;
    end
    if (state_r == ST_MUL) begin
      case (cnt_r)
        4'd0:    sq_r  <= prod[15:0];
        4'd1:    acc_r <= {2'd0, prod};
        4'd2:    acc_r <= acc_r + {2'd0, prod[15:0], 10'd0};
        4'd3:    sq_r  <= prod[15:0];
        default: acc_r <= acc_r + {2'd0, prod};
      endcase
      res_r <= 28'd0;
      bit_r <= ROOT_BIT0;
    end
    if (state_r == ST_ROOT) begin
      if (acc_r >= trial) begin
        acc_r <= acc_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // selection state and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= 10'd0;
      best_idx_r  <= 6'd0;
      best_pix_r  <= 24'd0;
      fc_r        <= 6'd0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (upd_go) begin
        best_dist_r <= nb_dist;
        best_idx_r  <= nb_idx;
        best_pix_r  <= nb_pix;
        fc_r        <= fc_new;
        open_r      <= !last_r;
      end
      if (upd_go && last_r) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {nb_dist, nb_idx, nb_pix};
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_MUL) && (cnt_r == 4'd0))
    else $error("accepted word did not start the multiply steps");

  a_root_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (res_r[27:14] == 14'd0))
    else $error("square root wider than 14 bits");

  a_fc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FRAME_LIM)
    else $error("frame count past limit");

  a_best_idx: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (best_idx_r <= fc_r))
    else $error("best index ahead of frame count");

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_UPD) && $past(last_r))
    else $error("result raised without a last word");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import wcdfs_pkg::*;

  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_FARTHEST = 2'd1;
  // spare reference selector, treated like the input reference
  localparam logic [1:0] REF_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } pixel_t;

  typedef struct {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [5:0] frame;
    logic [9:0] distance;
  } pick_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // cand_c0, cand_c1, cand_c2, ref_c0, ref_c1, ref_c2
  logic        in_tuser;   // first_frame
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // out_c0, out_c1, out_c2, chosen_frame, chosen_distance
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [1:0]  cfg_wdata;

  // predictor state
  logic       farthest_mode;
  logic [1:0] ref_mode;
  logic [9:0] best_dist;
  logic [5:0] best_frame;
  pixel_t     best_px;
  logic [5:0] frame_idx;
  bit         run_open;

  pick_t pending_picks[$];
  int    errors;
  int    words_sent;
  int    tx_run;
  int    rx_hold;
  int    rx_run;

  weighted_color_distance_frame_select_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic pixel_t px(input int c0, input int c1, input int c2);
    pixel_t p;
    p.c0 = 8'(c0);
    p.c1 = 8'(c1);
    p.c2 = 8'(c2);
    return p;
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t rand_px();
    return px(rand_byte(), rand_byte(), rand_byte());
  endfunction

  function automatic int unsigned absdiff8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // floor(isqrt(weighted sum) / 16); root built bit by bit from the top
  function automatic logic [9:0] redmean_distance(input pixel_t a, input pixel_t b);
    int unsigned m, d0, d1, d2, s, root, trial;
    int i;
    m = (int'(a.c0) + int'(b.c0)) / 2;
    d0 = absdiff8(a.c0, b.c0);
    d1 = absdiff8(a.c1, b.c1);
    d2 = absdiff8(a.c2, b.c2);
    s = (512 + m) * d0 * d0 + 1024 * d1 * d1 + (767 - m) * d2 * d2;
    root = 0;
    for (i = 13; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (trial * trial <= s) root = trial;
    end
    return 10'(root >> 4);
  endfunction

  task automatic weigh_candidate(input pixel_t cand, input pixel_t refp,
                                 input bit first, input bit last);
    pixel_t r;
    logic [9:0] d;
    bit take;
    pick_t p;
    r = refp;
    if (ref_mode == REF_BLACK) r = px(0, 0, 0);
    else if (ref_mode == REF_WHITE) r = px(255, 255, 255);
    d = redmean_distance(cand, r);
    if (first || !run_open) begin
      frame_idx = '0;
      take = 1'b1;
    end else begin
      if (frame_idx < FRAME_LIM) frame_idx = frame_idx + 6'd1;
      take = farthest_mode ? (d > best_dist) : (d < best_dist);
    end
    run_open = 1'b1;
    if (take) begin
      best_dist = d;
      best_frame = frame_idx;
      best_px = cand;
    end
    if (last) begin
      run_open = 1'b0;
      p.c0 = best_px.c0;
      p.c1 = best_px.c1;
      p.c2 = best_px.c2;
      p.frame = best_frame;
      p.distance = best_dist;
      pending_picks = {pending_picks, p};
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_tdata));
      end else begin
        want = pending_picks.pop_front();
        check_field("out_c0", int'(out_tdata[7:0]), int'(want.c0));
        check_field("out_c1", int'(out_tdata[15:8]), int'(want.c1));
        check_field("out_c2", int'(out_tdata[23:16]), int'(want.c2));
        check_field("chosen_frame", int'(out_tdata[29:24]), int'(want.frame));
        check_field("chosen_distance", int'(out_tdata[39:30]), int'(want.distance));
      end
    end
  end

  // result side back-pressure: short stalls, some long ones, quiet stretches
  always @(negedge clk) begin
    int r;
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_run > 0) begin
      rx_run--;
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) rx_run = $urandom_range(1, 30);
      else if (r < 90) rx_hold = $urandom_range(1, 4);
      else if (r < 97) rx_hold = $urandom_range(5, 40);
      else rx_run = $urandom_range(100, 400);
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_run > 0) begin
      tx_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 75) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 12);
    if (r < 95) return $urandom_range(20, 60);
    tx_run = $urandom_range(30, 120);
    return 0;
  endfunction

  task automatic send_word(input pixel_t cand, input pixel_t refp,
                           input bit first, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {refp, cand};
    in_tuser <= first;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    weigh_candidate(cand, refp, first, last);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PICK_FARTHEST) farthest_mode = val[0];
    else ref_mode = val;
  endtask

  task automatic send_run(input int len);
    pixel_t refp, cand;
    int i;
    refp = rand_px();
    cand = rand_px();
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 3) refp = rand_px();
      // occasionally repeat the candidate so distances tie
      if ($urandom_range(0, 4) != 0) cand = rand_px();
      send_word(cand, refp, i == 0, i == len - 1);
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n)
      send_word(rand_px(), rand_px(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  function automatic int pick_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 12);
    if (r < 98) return $urandom_range(13, 30);
    return $urandom_range(64, 72);
  endfunction

  // reset config: nearest, reference from input
  task automatic test_edge_pixels();
    // no first mark right after reset
    send_word(px(10, 20, 30), px(0, 0, 0), 1'b0, 1'b0);
    send_word(px(255, 255, 255), px(0, 0, 0), 1'b0, 1'b0);
    send_word(px(0, 0, 0), px(0, 0, 0), 1'b0, 1'b1);
    send_word(px(255, 255, 255), px(0, 0, 0), 1'b1, 1'b1);
    send_word(px(0, 0, 0), px(255, 255, 255), 1'b1, 1'b1);
    send_word(px(255, 0, 255), px(0, 255, 0), 1'b1, 1'b1);
    send_word(px(0, 255, 0), px(255, 0, 255), 1'b1, 1'b1);
    send_word(px(255, 0, 0), px(0, 0, 0), 1'b1, 1'b1);
    send_word(px(0, 0, 255), px(0, 0, 0), 1'b1, 1'b1);
    send_word(px(128, 127, 1), px(127, 128, 254), 1'b1, 1'b1);
    // no first mark after a closed selection
    send_word(px(1, 2, 3), px(3, 2, 1), 1'b0, 1'b1);
  endtask

  task automatic test_ties_and_restart();
    drain_results();
    write_reg(CFG_PICK_FARTHEST, MODE_FARTHEST);
    send_word(px(90, 40, 200), px(5, 5, 5), 1'b1, 1'b0);
    send_word(px(90, 40, 200), px(5, 5, 5), 1'b0, 1'b0);
    send_word(px(90, 40, 200), px(5, 5, 5), 1'b0, 1'b1);
    // first mark mid-run restarts the selection
    send_word(px(255, 255, 255), px(0, 0, 0), 1'b1, 1'b0);
    send_word(px(20, 20, 20), px(0, 0, 0), 1'b0, 1'b0);
    send_word(px(30, 30, 30), px(0, 0, 0), 1'b1, 1'b0);
    send_word(px(60, 10, 60), px(0, 0, 0), 1'b0, 1'b1);
    drain_results();
    write_reg(CFG_PICK_FARTHEST, MODE_NEAREST);
    send_word(px(200, 200, 200), px(100, 100, 100), 1'b1, 1'b0);
    send_word(px(110, 100, 90), px(100, 100, 100), 1'b0, 1'b0);
    send_word(px(110, 100, 90), px(100, 100, 100), 1'b0, 1'b1);
  endtask

  task automatic test_ref_sources();
    logic [1:0] srcs[3];
    int k;
    srcs = '{REF_BLACK, REF_WHITE, REF_SPARE};
    for (k = 0; k < 3; k++) begin
      drain_results();
      write_reg(CFG_REF_SOURCE, srcs[k]);
      send_word(rand_px(), rand_px(), 1'b1, 1'b0);
      send_word(rand_px(), rand_px(), 1'b0, 1'b1);
    end
  endtask

  // frame index must stick at its limit on long runs
  task automatic test_saturation();
    int i;
    drain_results();
    write_reg(CFG_PICK_FARTHEST, MODE_FARTHEST);
    write_reg(CFG_REF_SOURCE, REF_BLACK);
    for (i = 0; i < 69; i++)
      send_word(px($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200)),
                rand_px(), i == 0, 1'b0);
    send_word(px(255, 255, 255), rand_px(), 1'b0, 1'b1);
    drain_results();
    write_reg(CFG_PICK_FARTHEST, MODE_NEAREST);
    for (i = 0; i < 69; i++)
      send_word(px($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 255)),
                rand_px(), i == 0, 1'b0);
    send_word(px(0, 0, 0), rand_px(), 1'b0, 1'b1);
  endtask

  task automatic test_random_runs();
    logic [1:0] srcs[4];
    int phase, quota;
    srcs = '{REF_INPUT, REF_BLACK, REF_WHITE, REF_SPARE};
    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      write_reg(CFG_PICK_FARTHEST, phase[0] ? MODE_FARTHEST : MODE_NEAREST);
      write_reg(CFG_REF_SOURCE, srcs[phase / 2]);
      quota = words_sent + 135;
      while (words_sent < quota) begin
        if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 6));
        else send_run(pick_run_len());
      end
      // close any open selection before the next settings
      send_word(rand_px(), rand_px(), $urandom_range(0, 1), 1'b1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_PICK_FARTHEST;
    cfg_wdata = MODE_NEAREST;
    farthest_mode = 1'b0;
    ref_mode = REF_INPUT;
    best_dist = '0;
    best_frame = '0;
    best_px = '0;
    frame_idx = '0;
    run_open = 1'b0;
    errors = 0;
    words_sent = 0;
    tx_run = 0;
    rx_hold = 0;
    rx_run = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_pixels();
    test_ties_and_restart();
    test_ref_sources();
    test_saturation();
    test_random_runs();
    drain_results();

    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
sv/wcdfs_pkg.sv
sv/weighted_color_distance_frame_select_top.sv
tb/tb.sv
